// ----- rtl/hwa_pkg.sv -----
// Shared types and constants for the hopping window average block.
package hwa_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 8;
   localparam int AVG_BITS      = 24;
   localparam int CSR_BITS      = 9;

   localparam logic CSR_WIN_LEN = 1'b0;
   localparam logic CSR_HOP     = 1'b1;

   localparam logic [CSR_BITS-1:0] WIN_LEN_RESET = 9'd8;
   localparam logic [CSR_BITS-1:0] HOP_RESET     = 9'd1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [AVG_BITS-1:0] average;
      logic                       partial;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic load_out;
      logic rd_issue;
      logic drop;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic full;
      logic drain_more;
      logic div_done;
   } sts_type;

endpackage

// ----- rtl/hwa_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module hwa_div #(
   parameter int DIV_W = 32,
   parameter int WS_W  = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [WS_W-1:0]  divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [WS_W-1:0]  rem_ff, rem_in;
   logic [WS_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WS_W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = WS_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[WS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- rtl/hwa_dpath.sv -----
// Datapath: window store, running sum, pointers, registers, divider and result register.
module hwa_dpath #(
   parameter int MAX_WINDOW = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [hwa_pkg::CSR_BITS-1:0]        csr_wdata,
   input  hwa_pkg::req_type                    req_data,
   input  hwa_pkg::cmd_type                    cmd,
   output hwa_pkg::sts_type                    sts,
   output hwa_pkg::rsp_type                    rsp_data
);

   localparam int SB     = hwa_pkg::SAMPLE_BITS;
   localparam int AB     = hwa_pkg::AVG_BITS;
   localparam int PTR_W  = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int WS_W   = $clog2(MAX_WINDOW + 1);
   localparam int CW     = (WS_W > hwa_pkg::CSR_BITS) ? WS_W : hwa_pkg::CSR_BITS;
   localparam int MAG_W  = SB + $clog2(MAX_WINDOW);
   localparam int SUM_W  = MAG_W + 1;
   localparam int DIV_W  = MAG_W + hwa_pkg::FRACTION_BITS;
   localparam logic [DIV_W-1:0] LIM_POS = DIV_W'((64'd1 << (AB - 1)) - 64'd1);
   localparam logic [DIV_W-1:0] LIM_NEG = DIV_W'(64'd1 << (AB - 1));

   logic [hwa_pkg::CSR_BITS-1:0] win_len_ff, hop_ff;
   logic [WS_W-1:0]              fill_ff, fill_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [PTR_W-1:0]             wp_ff, wp_in, op_ff, op_in;
   logic [WS_W-1:0]              drop_cnt_ff, drop_cnt_in;
   logic                         last_ff;
   logic                         neg_ff;
   logic [SB-1:0]                rd_data_ff;
   hwa_pkg::rsp_type             rsp_ff;
   logic [SB-1:0]                store [MAX_WINDOW];

   logic [WS_W-1:0]  ws_eff, hop_eff;
   logic [CW-1:0]    ws_ext, hop_ext;
   logic [MAG_W-1:0] mag;
   logic [DIV_W-1:0] quotient;
   logic             div_done;
   logic [AB-1:0]    avg_sat;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
   endfunction

   // effective window size and hop
   always_comb begin
      ws_ext  = CW'(win_len_ff);
      hop_ext = CW'(hop_ff);
      if (ws_ext == '0) begin
         ws_eff = WS_W'(1);
      end else if (ws_ext > CW'(MAX_WINDOW)) begin
         ws_eff = WS_W'(MAX_WINDOW);
      end else begin
         ws_eff = WS_W'(ws_ext);
      end
      if (hop_ext == '0) begin
         hop_eff = WS_W'(1);
      end else if (hop_ext > CW'(ws_eff)) begin
         hop_eff = ws_eff;
      end else begin
         hop_eff = WS_W'(hop_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= hwa_pkg::WIN_LEN_RESET;
         hop_ff     <= hwa_pkg::HOP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hwa_pkg::CSR_WIN_LEN: win_len_ff <= csr_wdata;
            hwa_pkg::CSR_HOP:     hop_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window state
   always_comb begin
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      wp_in       = wp_ff;
      op_in       = op_ff;
      drop_cnt_in = drop_cnt_ff;
      if (cmd.clear) begin
         fill_in = '0;
         sum_in  = '0;
         wp_in   = '0;
         op_in   = '0;
      end else if (cmd.accept) begin
         drop_cnt_in = '0;
         if (fill_ff != WS_W'(MAX_WINDOW)) begin
            fill_in = fill_ff + 1'b1;
            sum_in  = sum_ff + SUM_W'(req_data.sample);
            wp_in   = next_ptr(wp_ff);
         end
      end else if (cmd.drop) begin
         fill_in     = fill_ff - 1'b1;
         sum_in      = sum_ff - SUM_W'($signed(rd_data_ff));
         op_in       = next_ptr(op_ff);
         drop_cnt_in = drop_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         sum_ff      <= '0;
         wp_ff       <= '0;
         op_ff       <= '0;
         drop_cnt_ff <= '0;
      end else begin
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         wp_ff       <= wp_in;
         op_ff       <= op_in;
         drop_cnt_ff <= drop_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_ff <= req_data.last_sample;
      end
      if (cmd.div_start) begin
         neg_ff <= sum_ff[SUM_W-1];
      end
   end

   // window store
   always_ff @(posedge clock) begin
      if (cmd.accept && fill_ff != WS_W'(MAX_WINDOW)) begin
         store[wp_ff] <= req_data.sample;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= store[op_ff];
      end
   end

   assign mag = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);

   hwa_div #(
      .DIV_W (DIV_W),
      .WS_W  (WS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({mag, {hwa_pkg::FRACTION_BITS{1'b0}}}),
      .divisor  (ws_eff),
      .quotient (quotient),
      .done     (div_done)
   );

   // saturate and apply sign
   always_comb begin
      if (neg_ff) begin
         if (quotient >= LIM_NEG) begin
            avg_sat = LIM_NEG[AB-1:0];
         end else begin
            avg_sat = -quotient[AB-1:0];
         end
      end else if (quotient > LIM_POS) begin
         avg_sat = LIM_POS[AB-1:0];
      end else begin
         avg_sat = quotient[AB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.average <= avg_sat;
         rsp_ff.partial <= (fill_ff < ws_eff);
      end
   end

   assign rsp_data       = rsp_ff;
   assign sts.last       = last_ff;
   assign sts.full       = (fill_ff >= ws_eff);
   assign sts.drain_more = (drop_cnt_ff < hop_eff) && (fill_ff != '0);
   assign sts.div_done   = div_done;

endmodule

// ----- rtl/hwa_ctrl.sv -----
// Controller: sequences accept, divide, result hand-off and oldest-sample drop.
module hwa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  hwa_pkg::sts_type sts,
   output hwa_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_DIV   = 6'b000100,
      S_PUSH  = 6'b001000,
      S_READ  = 6'b010000,
      S_DROP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.last || sts.full) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (sts.last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (sts.drain_more) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_DROP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DROP: begin
            cmd.drop = 1'b1;
            state_in = S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/hopping_window_average_top.sv -----
// Top level of the hopping window average block.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    hwa_pkg::req_type (sample, last_sample)
//   rsp      out        rsp_valid/rsp_ready    hwa_pkg::rsp_type (average, partial)
//   csr      in         csr_we                 csr_index, csr_wdata (window length, hop)
//
// One item at a time. A sample that yields no result passes through the accept and check
// states only. A result is computed by the bit-serial divider, and its hand-off waits
// while an earlier result waits for rsp_ready. Dropping then reads and drops each sample
// in turn through the single store read port, and finishes with a final drain check.
// A waiting result does not block the next item; a new result waits for rsp_ready.
// Reset is synchronous; no clearing pass is needed.
module hopping_window_average_top #(
   parameter int MAX_WINDOW = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  hwa_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output hwa_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [hwa_pkg::CSR_BITS-1:0] csr_wdata
);

   hwa_pkg::cmd_type cmd;
   hwa_pkg::sts_type sts;

   hwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hwa_dpath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/hwa_checker.sv -----
// Port-level assertions for the hopping window average block, bound to the top level.
module hwa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hwa_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("next item taken before the current one finished");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 !$rose(rsp_valid))
      else $error("result appeared before the divide could finish");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind hopping_window_average_top hwa_checker u_hwa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
